@@ hdl/fccc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fccc_pkg;

  localparam int MAX_VERTICES_DEF = 10;
  localparam int CLASS_SLOTS      = 10;
  localparam int EDGE_W           = 45;
  localparam int CLASS_W          = 40;
  localparam int NIB_W            = 4;
  localparam int VCNT_W           = 4;
  localparam int COLOR_W          = 4;
  localparam int COUNT_W          = 22;
  localparam int SUM_W            = 8;
  localparam int SLOT_W           = 4;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 4'd7;

  typedef logic [VCNT_W-1:0]  vcnt_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [NIB_W-1:0]   nib_t;
  typedef logic [SLOT_W-1:0]  slot_t;

endpackage

`default_nettype wire

@@ hdl/fccc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fccc_in_if;
  logic                         valid;
  logic                         ready;
  logic [fccc_pkg::EDGE_W-1:0]  edge_mask;
  logic [fccc_pkg::CLASS_W-1:0] class_sizes;

  modport source (output valid, output edge_mask, output class_sizes, input ready);
  modport sink   (input valid, input edge_mask, input class_sizes, output ready);
endinterface

interface fccc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fccc_pkg::COUNT_W-1:0] coloring_count;
  logic                         size_error;

  modport source (output valid, output coloring_count, output size_error, input ready);
  modport sink   (input valid, input coloring_count, input size_error, output ready);
endinterface

`default_nettype wire

@@ hdl/fixed_class_coloring_counter.sv @@
// Steps: add up the class sizes, check them, then walk each distinct permutation of the
// class word (at most 10! = 3628800), and hand the result to the output register.
// A size error skips the permutation walk.
// Throughput: one word at a time; the next word is taken while the last result waits.
// Reset (rst_ni low, asynchronous) empties the block and sets vertex_count to 7.
`timescale 1ns / 1ps
`default_nettype none

module fixed_class_coloring_counter #(
  parameter int MAX_VERTICES = fccc_pkg::MAX_VERTICES_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [fccc_pkg::VCNT_W-1:0]  cfg_wdata_i,
  fccc_in_if.sink                     in_i,
  fccc_out_if.source                  out_o
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam fccc_pkg::vcnt_t MaxV = fccc_pkg::vcnt_t'(MAX_VERTICES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  fccc_pkg::vcnt_t vcount_q;

  logic [fccc_pkg::EDGE_W-1:0]  edges_q, edges_d;
  logic [fccc_pkg::CLASS_W-1:0] class_q, class_d;
  fccc_pkg::slot_t  slot_q, slot_d;
  fccc_pkg::sum_t   sum_q, sum_d;
  fccc_pkg::color_t col_q [MAX_VERTICES];
  fccc_pkg::color_t col_d [MAX_VERTICES];
  fccc_pkg::count_t cnt_q, cnt_d;
  logic             err_q, err_d;

  logic             out_valid_q, out_valid_d;
  fccc_pkg::count_t out_cnt_q, out_cnt_d;
  logic             out_err_q, out_err_d;

  fccc_pkg::nib_t   nib;
  logic             sum_end;
  logic             proper;
  logic             has_pivot;
  logic [VW-1:0]    piv;
  logic [VW-1:0]    swp;
  fccc_pkg::color_t piv_col;
  fccc_pkg::color_t swapped [MAX_VERTICES];
  fccc_pkg::color_t nxt_col [MAX_VERTICES];

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.coloring_count  = out_cnt_q;
  assign out_o.size_error      = out_err_q;

  // Current class size; slots past the last one read as zero.
  always_comb begin
    nib = '0;
    for (int s = 0; s < fccc_pkg::CLASS_SLOTS; s++) begin
      if (slot_q == fccc_pkg::slot_t'(s)) begin
        nib = class_q[s*fccc_pkg::NIB_W +: fccc_pkg::NIB_W];
      end
    end
    sum_end = (slot_q == fccc_pkg::slot_t'(fccc_pkg::CLASS_SLOTS)) || (nib == '0);
  end

  // Proper test: no edge among the active vertices joins two equal colors.
  always_comb begin
    int pos;
    pos    = 0;
    proper = 1'b1;
    for (int b = 1; b < MAX_VERTICES; b++) begin
      for (int a = 0; a < b; a++) begin
        if (vcount_q > fccc_pkg::vcnt_t'(b) && edges_q[pos] && col_q[a] == col_q[b]) begin
          proper = 1'b0;
        end
        pos++;
      end
    end
  end

  // Lexicographic next permutation over the first vertex_count entries.
  always_comb begin
    int src;
    has_pivot = 1'b0;
    piv       = '0;
    for (int i = 0; i < MAX_VERTICES - 1; i++) begin
      if (fccc_pkg::vcnt_t'(i + 1) < vcount_q && col_q[i] < col_q[i + 1]) begin
        has_pivot = 1'b1;
        piv       = VW'(i);
      end
    end
    piv_col = col_q[piv];
    swp     = piv;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (fccc_pkg::vcnt_t'(j) < vcount_q && VW'(j) > piv && col_q[j] > piv_col) begin
        swp = VW'(j);
      end
    end
    for (int t = 0; t < MAX_VERTICES; t++) begin
      swapped[t] = col_q[t];
      if (VW'(t) == piv) begin
        swapped[t] = col_q[swp];
      end else if (VW'(t) == swp) begin
        swapped[t] = piv_col;
      end
    end
    // The tail after the pivot is reversed.
    for (int t = 0; t < MAX_VERTICES; t++) begin
      src        = int'(piv) + int'(vcount_q) - t;
      nxt_col[t] = swapped[t];
      if (VW'(t) > piv && fccc_pkg::vcnt_t'(t) < vcount_q) begin
        nxt_col[t] = swapped[VW'(src)];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    edges_d     = edges_q;
    class_d     = class_q;
    slot_d      = slot_q;
    sum_d       = sum_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    out_err_d   = out_err_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          edges_d = in_i.edge_mask;
          class_d = in_i.class_sizes;
          slot_d  = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sum_end) begin
          state_d = S_CHECK;
        end else begin
          // Colors are laid down in nondecreasing order: this class fills [sum, sum + size).
          for (int v = 0; v < MAX_VERTICES; v++) begin
            if (fccc_pkg::sum_t'(v) >= sum_q &&
                fccc_pkg::sum_t'(v) < sum_q + fccc_pkg::sum_t'(nib)) begin
              col_d[v] = fccc_pkg::color_t'(slot_q);
            end
          end
          sum_d  = sum_q + fccc_pkg::sum_t'(nib);
          slot_d = slot_q + 1'b1;
        end
      end
      S_CHECK: begin
        if (vcount_q == '0 || vcount_q > MaxV ||
            sum_q != fccc_pkg::sum_t'(vcount_q)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          err_d   = 1'b0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + fccc_pkg::count_t'(proper);
        if (has_pivot) begin
          col_d = nxt_col;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= fccc_pkg::VCNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edges_q   <= edges_d;
    class_q   <= class_d;
    slot_q    <= slot_d;
    sum_q     <= sum_d;
    col_q     <= col_d;
    cnt_q     <= cnt_d;
    err_q     <= err_d;
    out_cnt_q <= out_cnt_d;
    out_err_q <= out_err_d;
  end

endmodule

`default_nettype wire
